@@ sv/osd_pkg.sv @@
// shared types and constants for the obstacle side debounce block
package osd_pkg;

	localparam int unsigned POS_W   = 16;
	localparam int unsigned SLOPE_W = 10;
	localparam int unsigned HOLD_W  = 8;
	localparam int unsigned DIST_W  = 32;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_SLOPE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT   = 1'd1;

	localparam logic [SLOPE_W-1:0] SLOPE_RESET = 10'd586;
	localparam logic [HOLD_W-1:0]  HOLD_RESET  = 8'd10;
	localparam logic [DIST_W-1:0]  DIST_NONE   = '1;

	typedef struct packed {
		logic signed [POS_W-1:0] fwd_pos;
		logic signed [POS_W-1:0] side_pos;
		logic                    point_valid;
		logic                    frame_last;
	} osd_in_t;

	typedef struct packed {
		logic left_obstacle;
		logic right_obstacle;
	} osd_out_t;

endpackage

@@ sv/osd_in_if.sv @@
// obstacle point channel
interface osd_in_if;
	import osd_pkg::*;

	logic    valid;
	logic    ready;
	osd_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/osd_out_if.sv @@
// side decision channel
interface osd_out_if;
	import osd_pkg::*;

	logic     valid;
	logic     ready;
	osd_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/obstacle_side_debounce.sv @@
// obstacle side debounce: per-side nearest obstacle and held left/right decision
//
// Accepts one obstacle centre per cycle. A point passes through three pipeline
// registers (capture, squares and sector limit, distance and sector test) and is
// then folded into the per-side minima; on the last item of a frame the flags are
// updated and one decision transfer is presented from the output register.
// Throughput is one item per cycle; the only stall is a frame-end item
// that meets a decision still waiting in the output register.
module obstacle_side_debounce (
	input  logic                            clk,
	input  logic                            arst_n,
	osd_in_if.sink                          obstacle,
	osd_out_if.source                       decision,
	input  logic                            cfg_we,
	input  logic [osd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [osd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import osd_pkg::*;

	typedef struct packed {
		logic              left_flag;
		logic              right_flag;
		logic [HOLD_W-1:0] hold_count;
	} decide_t;

	logic [SLOPE_W-1:0] slope_q;
	logic [HOLD_W-1:0]  hold_limit_q;

	// stage 1: captured item
	logic                    vld_s1;
	logic signed [POS_W-1:0] fwd_s1;
	logic signed [POS_W-1:0] side_s1;
	logic                    pv_s1;
	logic                    last_s1;

	// stage 2: squares and sector limit
	logic              vld_s2;
	logic              ok_s2;
	logic              right_s2;
	logic              last_s2;
	logic [14:0]       fmag_s2;
	logic [29:0]       ff_s2;
	logic [30:0]       ll_s2;
	logic [26:0]       lim_s2;

	// stage 3: distance and side
	logic              vld_s3;
	logic              left_s3;
	logic              right_s3;
	logic              last_s3;
	logic [DIST_W-1:0] d_s3;

	logic [DIST_W-1:0] min_left_q;
	logic [DIST_W-1:0] min_right_q;
	logic              left_flag_q;
	logic              right_flag_q;
	logic [HOLD_W-1:0] hold_q;

	logic              out_vld_q;
	osd_out_t          out_q;

	logic              adv3, rdy3, rdy2, rdy1;
	logic [16:0]       side_mag;
	logic              side_nz;
	logic [30:0]       ll_full;
	logic [26:0]       lim_full;
	logic [24:0]       fs;
	logic              in_sec;
	logic [DIST_W-1:0] new_left, new_right;
	logic              hold_ok;
	decide_t           dec;

	// handshake chain
	assign adv3 = vld_s3 && (!last_s3 || !out_vld_q || decision.ready);
	assign rdy3 = !vld_s3 || adv3;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign obstacle.ready = rdy1;

	assign decision.valid = out_vld_q;
	assign decision.data  = out_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q      <= SLOPE_RESET;
			hold_limit_q <= HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SECTOR_SLOPE: slope_q <= cfg_data[SLOPE_W-1:0];
				REG_HOLD_LIMIT:   hold_limit_q <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy1) begin
			vld_s1 <= obstacle.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && obstacle.valid) begin
			fwd_s1  <= obstacle.data.fwd_pos;
			side_s1 <= obstacle.data.side_pos;
			pv_s1   <= obstacle.data.point_valid;
			last_s1 <= obstacle.data.frame_last;
		end
	end

	// stage 2
	always_comb begin
		side_mag = side_s1[POS_W-1] ? 17'(-{side_s1[POS_W-1], side_s1})
		                            : {1'b0, side_s1};
		side_nz  = (side_s1 != '0);
		ll_full  = 31'(side_mag * side_mag);
		lim_full = 27'(side_mag * slope_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && vld_s1) begin
			ok_s2    <= pv_s1 && side_nz && !fwd_s1[POS_W-1] && (fwd_s1 != '0);
			right_s2 <= side_s1[POS_W-1];
			last_s2  <= last_s1;
			fmag_s2  <= fwd_s1[14:0];
			ff_s2    <= 30'(fwd_s1[14:0] * fwd_s1[14:0]);
			ll_s2    <= ll_full;
			lim_s2   <= lim_full;
		end
	end

	// stage 3
	always_comb begin
		fs     = {fmag_s2, 10'b0};
		in_sec = ({2'b0, fs} > lim_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && vld_s2) begin
			d_s3     <= DIST_W'({2'b0, ff_s2}) + DIST_W'({1'b0, ll_s2});
			right_s3 <= ok_s2 && in_sec && right_s2;
			left_s3  <= ok_s2 && in_sec && !right_s2;
			last_s3  <= last_s2;
		end
	end

	// minima and frame decision
	always_comb begin
		new_left  = (left_s3 && (d_s3 < min_left_q)) ? d_s3 : min_left_q;
		new_right = (right_s3 && (d_s3 < min_right_q)) ? d_s3 : min_right_q;
		hold_ok   = (hold_q < hold_limit_q);
		dec.left_flag  = left_flag_q;
		dec.right_flag = right_flag_q;
		dec.hold_count = hold_q + 1'b1;
		if (new_left == new_right) begin
			if (!((left_flag_q || right_flag_q) && hold_ok)) begin
				dec = '{left_flag: 1'b0, right_flag: 1'b0, hold_count: '0};
			end
		end else if (new_left < new_right) begin
			if (!(right_flag_q && hold_ok)) begin
				dec = '{left_flag: 1'b1, right_flag: 1'b0, hold_count: '0};
			end
		end else begin
			if (!(left_flag_q && hold_ok)) begin
				dec = '{left_flag: 1'b0, right_flag: 1'b1, hold_count: '0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_left_q   <= DIST_NONE;
			min_right_q  <= DIST_NONE;
			left_flag_q  <= 1'b0;
			right_flag_q <= 1'b0;
			hold_q       <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			out_vld_q <= (adv3 && last_s3) || (out_vld_q && !decision.ready);
			if (adv3) begin
				if (last_s3) begin
					min_left_q   <= DIST_NONE;
					min_right_q  <= DIST_NONE;
					left_flag_q  <= dec.left_flag;
					right_flag_q <= dec.right_flag;
					hold_q       <= dec.hold_count;
				end else begin
					min_left_q  <= new_left;
					min_right_q <= new_right;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && last_s3) begin
			out_q.left_obstacle  <= dec.left_flag;
			out_q.right_obstacle <= dec.right_flag;
		end
	end

endmodule

@@ test/obstacle_side_debounce_test.sv @@
// testbench for obstacle_side_debounce: directed and random obstacle frames checked against a predictor
`timescale 1ns / 100ps

module obstacle_side_debounce_test;
	import osd_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int HOLDOFF_LEN   = 300;
	localparam int DRAIN_CYCLES  = 8;

	typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE} rx_pattern_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	osd_in_if  obstacle_ch ();
	osd_out_if decision_ch ();

	obstacle_side_debounce i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.obstacle (obstacle_ch),
		.decision (decision_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state and register copies
	logic [SLOPE_W-1:0] sector_slope = SLOPE_RESET;
	logic [HOLD_W-1:0]  hold_limit   = HOLD_RESET;
	logic [DIST_W-1:0]  nearest_left  = DIST_NONE;
	logic [DIST_W-1:0]  nearest_right = DIST_NONE;
	logic               held_left  = 1'b0;
	logic               held_right = 1'b0;
	logic [HOLD_W-1:0]  hold_frames = '0;

	osd_in_t  pending_points[$];
	osd_out_t expected_decisions[$];

	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int holdoff_requests = 0;
	int holdoff_granted = 0;
	int holdoff_left = 0;
	int rx_stretch = 0;
	rx_pattern_t rx_pattern = RX_ALWAYS;

	function automatic void fold_obstacle(input osd_in_t it);
		longint fwd, lat, reach;
		logic [DIST_W-1:0] sq_dist;
		logic want_left, want_right, changing;
		osd_out_t flags;
		fwd = longint'($signed(it.fwd_pos));
		lat = -longint'($signed(it.side_pos));
		if (it.point_valid && fwd > 0 && lat != 0) begin
			sq_dist = DIST_W'(fwd * fwd + lat * lat);
			reach = (lat > 0 ? lat : -lat) * longint'(sector_slope);
			if (fwd * 1024 > reach) begin
				if (lat > 0 && sq_dist < nearest_right)
					nearest_right = sq_dist;
				if (lat < 0 && sq_dist < nearest_left)
					nearest_left = sq_dist;
			end
		end
		if (it.frame_last) begin
			if (nearest_left == nearest_right) begin
				want_left = 1'b0;
				want_right = 1'b0;
				changing = held_left || held_right;
			end else if (nearest_left < nearest_right) begin
				want_left = 1'b1;
				want_right = 1'b0;
				changing = held_right;
			end else begin
				want_left = 1'b0;
				want_right = 1'b1;
				changing = held_left;
			end
			if (changing && hold_frames < hold_limit) begin
				hold_frames = hold_frames + 1'b1;
			end else begin
				held_left = want_left;
				held_right = want_right;
				hold_frames = '0;
			end
			flags.left_obstacle = held_left;
			flags.right_obstacle = held_right;
			expected_decisions.push_back(flags);
			nearest_left = DIST_NONE;
			nearest_right = DIST_NONE;
		end
	endfunction

	function automatic osd_in_t obstacle_item(input int fwd, input int side, input bit valid,
			input bit last);
		osd_in_t it;
		it.fwd_pos = 16'(fwd);
		it.side_pos = 16'(side);
		it.point_valid = valid;
		it.frame_last = last;
		return it;
	endfunction

	function automatic logic [POS_W-1:0] random_coord(input bit forward);
		case ($urandom_range(0, 9))
			0, 1: return 16'($urandom);
			2: begin
				case ($urandom_range(0, 4))
					0: return 16'h7fff;
					1: return 16'h8000;
					2: return 16'h0000;
					3: return 16'h0001;
					default: return 16'hffff;
				endcase
			end
			default: begin
				if (forward)
					return 16'($urandom_range(0, 3000)) - 16'd200;
				return 16'($urandom_range(0, 6000)) - 16'd3000;
			end
		endcase
	endfunction

	task automatic queue_frames(input int count, input int max_len);
		int remaining;
		int len;
		osd_in_t it;
		remaining = count;
		while (remaining > 0) begin
			len = $urandom_range(1, max_len);
			if (len > remaining)
				len = remaining;
			for (int k = 0; k < len; k++) begin
				it.fwd_pos = random_coord(1'b1);
				it.side_pos = random_coord(1'b0);
				it.point_valid = ($urandom_range(0, 9) != 0);
				it.frame_last = (k == len - 1);
				pending_points.push_back(it);
			end
			remaining -= len;
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SECTOR_SLOPE)
			sector_slope = value[SLOPE_W-1:0];
		else
			hold_limit = value[HOLD_W-1:0];
	endtask

	task automatic configure(input int slope, input int hold);
		write_register(REG_SECTOR_SLOPE, CFG_DATA_W'(slope));
		write_register(REG_HOLD_LIMIT, CFG_DATA_W'(hold));
	endtask

	// wait for every transfer and decision, then let the pipeline empty
	task automatic settle();
		while (pending_points.size() != 0 || obstacle_ch.valid || expected_decisions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			obstacle_ch.valid <= 1'b0;
		end else if (!obstacle_ch.valid || obstacle_ch.ready) begin
			if (obstacle_ch.valid)
				fold_obstacle(obstacle_ch.data);
			if (gap_left != 0 || pending_points.size() == 0) begin
				obstacle_ch.valid <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end else begin
				obstacle_ch.valid <= 1'b1;
				obstacle_ch.data <= pending_points.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			decision_ch.ready <= 1'b0;
		end else if (holdoff_left != 0) begin
			holdoff_left--;
			decision_ch.ready <= 1'b0;
		end else if (holdoff_granted != holdoff_requests) begin
			holdoff_granted++;
			holdoff_left = HOLDOFF_LEN;
			decision_ch.ready <= 1'b0;
		end else begin
			if (rx_stretch == 0) begin
				rx_pattern = rx_pattern_t'($urandom_range(0, 2));
				rx_stretch = $urandom_range(8, 60);
			end else begin
				rx_stretch--;
			end
			case (rx_pattern)
				RX_ALWAYS: decision_ch.ready <= 1'b1;
				RX_COIN:   decision_ch.ready <= 1'($urandom_range(0, 1));
				default:   decision_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		osd_out_t want;
		if (arst_n && decision_ch.valid === 1'b1 && decision_ch.ready === 1'b1) begin
			if (expected_decisions.size() == 0) begin
				$error("decision transfer with none expected: left %0b right %0b",
					decision_ch.data.left_obstacle, decision_ch.data.right_obstacle);
				mismatches++;
			end else begin
				want = expected_decisions.pop_front();
				if (decision_ch.data.left_obstacle !== want.left_obstacle) begin
					$error("left_obstacle: expected %0b, got %0b",
						want.left_obstacle, decision_ch.data.left_obstacle);
					mismatches++;
				end
				if (decision_ch.data.right_obstacle !== want.right_obstacle) begin
					$error("right_obstacle: expected %0b, got %0b",
						want.right_obstacle, decision_ch.data.right_obstacle);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((obstacle_ch.valid && obstacle_ch.ready) || (decision_ch.valid && decision_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("obstacle_side_debounce_test failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames at the register reset values
		pending_points.push_back(obstacle_item(0, 0, 1'b0, 1'b1));
		pending_points.push_back(obstacle_item(256, -100, 1'b1, 1'b1));
		pending_points.push_back(obstacle_item(256, 100, 1'b1, 1'b1));
		// right point exactly on the sector edge, then a left point
		pending_points.push_back(obstacle_item(293, -512, 1'b1, 1'b0));
		pending_points.push_back(obstacle_item(200, 300, 1'b1, 1'b1));
		// behind the car, zero forward, zero lateral
		pending_points.push_back(obstacle_item(-300, -10, 1'b1, 1'b0));
		pending_points.push_back(obstacle_item(0, -10, 1'b1, 1'b0));
		pending_points.push_back(obstacle_item(500, 0, 1'b1, 1'b1));
		// coordinate extremes, ending on equal minima
		pending_points.push_back(obstacle_item(32767, -32768, 1'b1, 1'b0));
		pending_points.push_back(obstacle_item(32767, 32767, 1'b1, 1'b0));
		pending_points.push_back(obstacle_item(-32768, 32767, 1'b1, 1'b0));
		pending_points.push_back(obstacle_item(1, 1, 1'b1, 1'b0));
		pending_points.push_back(obstacle_item(1, -1, 1'b1, 1'b1));
		// invalid item carrying a near point
		pending_points.push_back(obstacle_item(100, -5, 1'b0, 1'b0));
		pending_points.push_back(obstacle_item(100, 50, 1'b1, 1'b1));
		pending_points.push_back(obstacle_item(300, 20, 1'b1, 1'b0));
		pending_points.push_back(obstacle_item(300, -20, 1'b1, 1'b1));
		settle();

		configure(0, 0);
		pending_points.push_back(obstacle_item(5, 3000, 1'b1, 1'b1));
		pending_points.push_back(obstacle_item(5, -3000, 1'b1, 1'b1));
		pending_points.push_back(obstacle_item(7, 0, 1'b1, 1'b1));
		queue_frames(250, 6);
		settle();

		configure(1023, 255);
		queue_frames(250, 6);
		settle();

		configure(1023, 0);
		queue_frames(250, 5);
		settle();

		configure($urandom_range(0, 1023), $urandom_range(1, 5));
		queue_frames(300, 6);
		settle();

		// output held off while single-item frames keep coming
		configure(586, 3);
		queue_frames(200, 1);
		holdoff_requests <= holdoff_requests + 1;
		settle();

		configure($urandom_range(0, 1023), $urandom_range(0, 2));
		queue_frames(400, 6);
		settle();

		if (expected_decisions.size() != 0) begin
			$error("%0d decision transfers never arrived", expected_decisions.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("obstacle_side_debounce_test passed");
		else
			$display("obstacle_side_debounce_test failed");
		$finish;
	end

endmodule

@@ sim.f @@
sv/osd_pkg.sv
sv/osd_in_if.sv
sv/osd_out_if.sv
sv/obstacle_side_debounce.sv
test/obstacle_side_debounce_test.sv
